// ===== rtl/core/olss_pkg.sv =====
`timescale 1ns / 1ps

package olss_pkg;

   // storage depth and the sizes that follow from it
   localparam int DEPTH   = 64;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);

   // fixed field widths of the channels
   localparam int TYPE_W   = 3;
   localparam int INDEX_W  = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int FIDX_W   = 7;
   localparam int COUNT_W  = 7;
   localparam int CAP_W    = 7;

   localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(64);
   localparam logic [FIDX_W-1:0] NO_INDEX  = '1;

   // match reduction: cells are grouped, groups are scanned a window at a time
   localparam int GRP       = 8;
   localparam int GRP_W     = $clog2(GRP);
   localparam int NGROUPS   = (DEPTH + GRP - 1) / GRP;
   localparam int NCELL_PAD = NGROUPS * GRP;
   localparam int WIN       = 8;
   localparam int WIN_W     = $clog2(WIN);
   localparam int NSCAN     = (NGROUPS + WIN - 1) / WIN;
   localparam int SCAN_W    = (NSCAN > 1) ? $clog2(NSCAN) : 1;
   localparam int NSCAN_PAD = 2 ** SCAN_W;
   localparam int HPOS_W    = SCAN_W + WIN_W + GRP_W;

   typedef enum logic [TYPE_W-1:0] {
      REQ_READ         = 3'd0,
      REQ_WRITE        = 3'd1,
      REQ_INSERT       = 3'd2,
      REQ_APPEND       = 3'd3,
      REQ_REMOVE_INDEX = 3'd4,
      REQ_REMOVE_VALUE = 3'd5,
      REQ_FIND         = 3'd6
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_RANGE   = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_GROUP,
      S_SCAN,
      S_APPLY
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN
   } cell_op_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type             op;
      logic                    load_match;
      logic                    match_by_pos;
      logic [IDX_W-1:0]        pos;
      logic [CNT_W-1:0]        count;
      logic [DATA_W-1:0]       value;
   } cell_ctrl_type;

   // registered summary of one group of cells
   typedef struct packed {
      logic                    any;
      logic [GRP_W-1:0]        idx;
      logic [DATA_W-1:0]       data;
   } grp_type;

endpackage

// ===== rtl/core/olss_req_if.sv =====
`timescale 1ns / 1ps

interface olss_req_if import olss_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [TYPE_W-1:0]         req_type;
   logic [INDEX_W-1:0]        index;
   logic signed [DATA_W-1:0]  value;

   modport source (output valid, req_type, index, value, input ready);
   modport sink   (input valid, req_type, index, value, output ready);
endinterface

// ===== rtl/core/olss_rsp_if.sv =====
`timescale 1ns / 1ps

interface olss_rsp_if import olss_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [DATA_W-1:0]  read_value;
   logic signed [FIDX_W-1:0]  found_index;
   logic [COUNT_W-1:0]        list_count;

   modport source (output valid, status, read_value, found_index, list_count, input ready);
   modport sink   (input valid, status, read_value, found_index, list_count, output ready);
endinterface

// ===== rtl/core/olss_csr_if.sv =====
`timescale 1ns / 1ps

interface olss_csr_if import olss_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CAP_W-1:0]    data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/olss_cell.sv =====
`timescale 1ns / 1ps

module olss_cell import olss_pkg::*; (
   input  logic                clock,
   input  logic [IDX_W-1:0]    cell_pos,
   input  cell_ctrl_type       ctrl,
   input  logic [DATA_W-1:0]   left_data,
   input  logic [DATA_W-1:0]   right_data,
   output logic [DATA_W-1:0]   entry_data,
   output logic                match
);

   logic [DATA_W-1:0] entry_ff, entry_in;
   logic              match_ff, match_in;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         CELL_WRITE: begin
            if (cell_pos == ctrl.pos) entry_in = ctrl.value;
         end
         CELL_SHIFT_UP: begin
            // take the lower neighbour above the slot, the new value at it
            if (cell_pos > ctrl.pos)       entry_in = left_data;
            else if (cell_pos == ctrl.pos) entry_in = ctrl.value;
         end
         CELL_SHIFT_DOWN: begin
            if (cell_pos >= ctrl.pos) entry_in = right_data;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      match_in = match_ff;
      if (ctrl.load_match) begin
         match_in = (ctrl.match_by_pos ? (cell_pos == ctrl.pos) : (entry_ff == ctrl.value))
                    && (CNT_W'(cell_pos) < ctrl.count);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry_data = entry_ff;
   assign match      = match_ff;

endmodule

// ===== rtl/core/olss_group.sv =====
`timescale 1ns / 1ps

module olss_group import olss_pkg::*; (
   input  logic                          clock,
   input  logic [GRP-1:0]                match,
   input  logic [GRP-1:0][DATA_W-1:0]    data,
   output grp_type                       grp
);

   grp_type grp_ff, grp_in;

   // lowest matching cell of the group wins
   always_comb begin
      grp_in = '0;
      for (int k = GRP - 1; k >= 0; k--) begin
         if (match[k]) begin
            grp_in.any  = 1'b1;
            grp_in.idx  = GRP_W'(k);
            grp_in.data = data[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   assign grp = grp_ff;

endmodule

// ===== rtl/core/ordered_list_shift_store_core.sv =====
`timescale 1ns / 1ps

// Ordered list of up to DEPTH (64) signed 32-bit entries held in a chain of
// cells, one entry per cell; insert and remove move every later entry by one
// cell together. Write, insert, append, remove at index and the unused
// request code finish in the cycle they are accepted: one request per cycle
// while no match-path request is in progress and the result register is
// free or being emptied. Read, find and remove value go through the match
// path: every cell compares in the accept cycle, groups of eight cells
// reduce to a registered summary, the group summaries are scanned eight per
// cycle, and a final apply step loads the result once the result register
// is free; these are accepted even while an earlier result waits. The
// capacity register (csr) is taken whenever written, reset value 64, and is
// clamped to DEPTH; write it only while the block is idle. Entries above the
// count hold no defined value and are never reported.
module ordered_list_shift_store_core import olss_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   olss_req_if.sink     req_chan,
   olss_rsp_if.source   rsp_chan,
   olss_csr_if.sink     csr_chan
);

   // ---------------------------------------------------------------
   // control and result registers
   // ---------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CAP_W-1:0]     cap_ff;
   req_code_type         code_ff, code_in;
   logic [SCAN_W-1:0]    scan_ff, scan_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     hit_pos_ff, hit_pos_in;
   logic [DATA_W-1:0]    hit_data_ff, hit_data_in;

   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [DATA_W-1:0]    rsp_read_ff;
   logic [FIDX_W-1:0]    rsp_found_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic                 out_load;
   status_type           out_status;
   logic [DATA_W-1:0]    out_read;
   logic [FIDX_W-1:0]    out_found;
   logic                 out_free;

   logic                 req_ready;
   logic                 req_accept;
   req_code_type         req_code;
   logic [IDX_W-1:0]     req_pos;
   logic [CAP_W-1:0]     eff_cap;
   logic                 list_full;
   logic                 pos_in_list;

   cell_ctrl_type        ctrl;

   // ---------------------------------------------------------------
   // chain of cells
   // ---------------------------------------------------------------
   logic [NCELL_PAD-1:0]              cell_match;
   logic [NCELL_PAD-1:0][DATA_W-1:0]  cell_data;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      olss_cell u_cell (
         .clock      (clock),
         .cell_pos   (IDX_W'(i)),
         .ctrl       (ctrl),
         .left_data  ((i == 0) ? ctrl.value : cell_data[(i == 0) ? 0 : i - 1]),
         .right_data ((i == DEPTH - 1) ? {DATA_W{1'b0}}
                                       : cell_data[(i == DEPTH - 1) ? i : i + 1]),
         .entry_data (cell_data[i]),
         .match      (cell_match[i])
      );
   end

   // tie off the padding cells of a partly filled last group
   for (genvar i = DEPTH; i < NCELL_PAD; i++) begin : g_cell_pad
      assign cell_match[i] = 1'b0;
      assign cell_data[i]  = '0;
   end

   // ---------------------------------------------------------------
   // group summaries, arranged as scan windows
   // ---------------------------------------------------------------
   grp_type grp_arr [NSCAN_PAD][WIN];

   for (genvar g = 0; g < NSCAN_PAD * WIN; g++) begin : g_grp
      if (g < NGROUPS) begin : g_real
         olss_group u_group (
            .clock (clock),
            .match (cell_match[g*GRP +: GRP]),
            .data  (cell_data[g*GRP +: GRP]),
            .grp   (grp_arr[g / WIN][g % WIN])
         );
      end else begin : g_pad
         assign grp_arr[g / WIN][g % WIN] = '0;
      end
   end

   // first hit of the window under scan
   logic                 win_hit;
   logic [WIN_W-1:0]     win_k;
   logic [GRP_W-1:0]     win_local;
   logic [DATA_W-1:0]    win_data;
   logic [HPOS_W-1:0]    win_pos_full;

   always_comb begin
      win_hit   = 1'b0;
      win_k     = '0;
      win_local = '0;
      win_data  = '0;
      for (int k = WIN - 1; k >= 0; k--) begin
         if (grp_arr[scan_ff][k].any) begin
            win_hit   = 1'b1;
            win_k     = WIN_W'(k);
            win_local = grp_arr[scan_ff][k].idx;
            win_data  = grp_arr[scan_ff][k].data;
         end
      end
      win_pos_full = {scan_ff, win_k, win_local};
   end

   // ---------------------------------------------------------------
   // request decode
   // ---------------------------------------------------------------
   assign req_code    = req_code_type'(req_chan.req_type);
   assign req_pos     = IDX_W'(req_chan.index);
   assign eff_cap     = (cap_ff > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_ff;
   assign list_full   = CAP_W'(count_ff) >= eff_cap;
   assign pos_in_list = CNT_W'(req_pos) < count_ff;
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept  = req_chan.valid && req_ready;

   // ---------------------------------------------------------------
   // sequencer: next state, cell control and result
   // ---------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      code_in     = code_ff;
      scan_in     = scan_ff;
      found_in    = found_ff;
      hit_pos_in  = hit_pos_ff;
      hit_data_in = hit_data_ff;

      out_load    = 1'b0;
      out_status  = ST_OK;
      out_read    = '0;
      out_found   = NO_INDEX;
      req_ready   = 1'b0;

      ctrl.op           = CELL_HOLD;
      ctrl.load_match   = 1'b0;
      ctrl.match_by_pos = 1'b0;
      ctrl.pos          = req_pos;
      ctrl.count        = count_ff;
      ctrl.value        = req_chan.value;

      case (state_ff)
         S_IDLE: begin
            // match-path requests need the result register only at the end
            req_ready = (req_code inside {REQ_READ, REQ_FIND, REQ_REMOVE_VALUE}) || out_free;
            if (req_accept) begin
               code_in  = req_code;
               scan_in  = '0;
               found_in = 1'b0;
               case (req_code)
                  REQ_READ: begin
                     ctrl.load_match   = 1'b1;
                     ctrl.match_by_pos = 1'b1;
                     state_in          = S_GROUP;
                  end
                  REQ_FIND, REQ_REMOVE_VALUE: begin
                     ctrl.load_match = 1'b1;
                     state_in        = S_GROUP;
                  end
                  REQ_WRITE: begin
                     out_load = 1'b1;
                     if (pos_in_list) ctrl.op = CELL_WRITE;
                     else             out_status = ST_RANGE;
                  end
                  REQ_INSERT: begin
                     out_load = 1'b1;
                     // full takes precedence over a bad position
                     if (list_full) begin
                        out_status = ST_FULL;
                     end else if (CNT_W'(req_pos) > count_ff) begin
                        out_status = ST_RANGE;
                     end else begin
                        ctrl.op  = CELL_SHIFT_UP;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  REQ_APPEND: begin
                     out_load = 1'b1;
                     if (list_full) begin
                        out_status = ST_FULL;
                     end else begin
                        ctrl.op  = CELL_SHIFT_UP;
                        ctrl.pos = IDX_W'(count_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  REQ_REMOVE_INDEX: begin
                     out_load = 1'b1;
                     if (pos_in_list) begin
                        ctrl.op  = CELL_SHIFT_DOWN;
                        count_in = count_ff - 1'b1;
                     end else begin
                        out_status = ST_RANGE;
                     end
                  end
                  default: begin
                     // unused code: report ok, change nothing
                     out_load = 1'b1;
                  end
               endcase
            end
         end

         S_GROUP: begin
            state_in = S_SCAN;
         end

         S_SCAN: begin
            // keep the first hit; later windows only cover higher positions
            if (!found_ff && win_hit) begin
               found_in    = 1'b1;
               hit_pos_in  = IDX_W'(win_pos_full);
               hit_data_in = win_data;
            end
            if (scan_ff == SCAN_W'(NSCAN - 1)) state_in = S_APPLY;
            else                               scan_in  = scan_ff + 1'b1;
         end

         S_APPLY: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
               case (code_ff)
                  REQ_READ: begin
                     if (found_ff) out_read   = hit_data_ff;
                     else          out_status = ST_RANGE;
                  end
                  REQ_FIND: begin
                     if (found_ff) out_found  = FIDX_W'(hit_pos_ff);
                     else          out_status = ST_MISSING;
                  end
                  REQ_REMOVE_VALUE: begin
                     if (found_ff) begin
                        out_found = FIDX_W'(hit_pos_ff);
                        ctrl.op   = CELL_SHIFT_DOWN;
                        ctrl.pos  = hit_pos_ff;
                        count_in  = count_ff - 1'b1;
                     end else begin
                        out_status = ST_MISSING;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         scan_ff      <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         found_ff <= found_in;
         scan_ff  <= scan_in;
         if (csr_chan.valid) cap_ff <= csr_chan.data;
         // hold the result until taken
         if (out_load)            rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      hit_pos_ff  <= hit_pos_in;
      hit_data_ff <= hit_data_in;
      if (out_load) begin
         rsp_status_ff <= out_status;
         rsp_read_ff   <= out_read;
         rsp_found_ff  <= out_found;
         rsp_count_ff  <= COUNT_W'(count_in);
      end
   end

   assign req_chan.ready       = req_ready;
   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.read_value  = rsp_read_ff;
   assign rsp_chan.found_index = rsp_found_ff;
   assign rsp_chan.list_count  = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_count_quiet: assert property (@(posedge clock) disable iff (reset)
      (!req_accept && state_ff != S_APPLY) |=> $stable(count_ff))
      else $error("entry count moved without a request");

   a_apply_issues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("match-path request did not deliver its result");
`endif

endmodule
